### hw/rtl/plte_pkg.sv
// Package: sizes, codes, request/response types and element helpers for the list engine.
`timescale 1ns / 1ps
`default_nettype none

package plte_pkg;

   localparam int CAPACITY      = 64;
   localparam int ELEMENT_WIDTH = 32;
   localparam int ADDR_W        = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int POS_W         = 7;
   localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] KIND_INSERT  = 3'd0;
   localparam logic [2:0] KIND_DELETE  = 3'd1;
   localparam logic [2:0] KIND_GET     = 3'd2;
   localparam logic [2:0] KIND_LOCATE  = 3'd3;
   localparam logic [2:0] KIND_REVERSE = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_POS   = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef logic signed [ELEMENT_WIDTH-1:0] elem_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [POS_W-1:0]  position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic [POS_W-1:0]   found_position;
      logic [POS_W-1:0]   list_length;
   } rsp_type;

   // Cut or sign-extend the request value to the stored element width.
   function automatic elem_type to_elem(input logic signed [31:0] v);
      to_elem = ELEMENT_WIDTH'(v);
   endfunction

   // Sign-extend or cut a stored element to the 32-bit response field.
   function automatic logic signed [31:0] from_elem(input elem_type e);
      from_elem = 32'(e);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/plte_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module plte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

### hw/rtl/positional_list_table_engine.sv
// Top level: ordered list of signed elements kept in a RAM, one command per request.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall req_data   (kind, position, value)
// rsp_      out        rsp_valid/rsp_stall rsp_data   (status, read_value,
//                                                      found_position, list_length)
//
// The single RAM write port sets the pace: one entry is moved per cycle.
// Reset clears the length and control state; RAM contents are left as they are.
// A new request is taken only while the sequencer is idle; a finished response
// waits in the output register while the next request is already accepted.

module positional_list_table_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire plte_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output plte_pkg::rsp_type     rsp_data
);

   import plte_pkg::*;

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INS    = 4'd1;  // stream entries up, top first
   localparam logic [3:0] S_DEL    = 4'd2;  // stream entries down, bottom first
   localparam logic [3:0] S_DRAIN  = 4'd3;  // write the last streamed entry
   localparam logic [3:0] S_INS_V  = 4'd4;  // drop the new value into its slot
   localparam logic [3:0] S_GET    = 4'd5;
   localparam logic [3:0] S_LOC    = 4'd6;
   localparam logic [3:0] S_REV_RD = 4'd7;
   localparam logic [3:0] S_REV_W1 = 4'd8;
   localparam logic [3:0] S_REV_W2 = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   // Control registers
   logic [3:0]        state_ff,     state_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic              pend_ff,      pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [2:0]        op_ff,        op_in;
   logic [ADDR_W-1:0] ptr_ff,       ptr_in;
   logic [ADDR_W-1:0] end_ff,       end_in;
   logic [ADDR_W-1:0] tag_ff,       tag_in;
   elem_type          value_ff,     value_in;
   elem_type          hold_ff,      hold_in;
   logic [2:0]        status_ff,    status_in;
   logic signed [31:0] rdval_ff,    rdval_in;
   logic [POS_W-1:0]  found_ff,     found_in;
   rsp_type           rsp_ff,       rsp_in;

   // RAM ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   elem_type          wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   elem_type          rd_data_a;
   elem_type          rd_data_b;

   // Request decode
   logic              accept;
   logic [CMP_W-1:0]  pos_c;
   logic [CMP_W-1:0]  cnt_c;
   logic              is_full;
   logic              is_empty;
   logic              ins_ok;
   logic              pos_in_list;
   logic              rev_more;
   logic              rsp_free;

   plte_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign pos_c       = CMP_W'(req_data.position);
   assign cnt_c       = CMP_W'(count_ff);
   assign is_full     = (count_ff >= CNT_W'(CAPACITY));
   assign is_empty    = (count_ff == '0);
   assign ins_ok      = !is_full && (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
   assign pos_in_list = (pos_c != '0) && (pos_c <= cnt_c);

   // Another pair lies strictly inside the current one
   assign rev_more = (({1'b0, ptr_ff} + (ADDR_W + 1)'(2)) < {1'b0, end_ff});

   // Read addresses: port A follows the stream, port B only serves reverse
   always_comb begin
      unique case (state_ff)
         S_IDLE:   rd_addr_a = ADDR_W'(pos_c - CMP_W'(1));
         S_INS:    rd_addr_a = ptr_ff - ADDR_W'(1);
         S_REV_W2: rd_addr_a = ptr_ff + ADDR_W'(1);
         default:  rd_addr_a = ptr_ff;
      endcase
      rd_addr_b = (state_ff == S_REV_W2) ? (end_ff - ADDR_W'(1)) : end_ff;
   end

   // Write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tag_ff;
      wr_data = rd_data_a;
      unique case (state_ff)
         S_INS, S_DEL, S_DRAIN: begin
            wr_en = pend_ff;
         end
         S_INS_V: begin
            wr_en   = 1'b1;
            wr_addr = end_ff;
            wr_data = value_ff;
         end
         S_REV_W1: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data_b;
         end
         S_REV_W2: begin
            wr_en   = 1'b1;
            wr_addr = end_ff;
            wr_data = hold_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      tag_in       = tag_ff;
      value_in     = value_ff;
      hold_in      = hold_ff;
      status_in    = status_ff;
      rdval_in     = rdval_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.kind;
               value_in  = to_elem(req_data.value);
               status_in = STATUS_OK;
               rdval_in  = '0;
               found_in  = '0;
               pend_in   = 1'b0;
               state_in  = S_RESP;
               unique case (req_data.kind)
                  KIND_INSERT: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else if (!ins_ok) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        ptr_in   = ADDR_W'(count_ff);
                        end_in   = ADDR_W'(pos_c - CMP_W'(1));
                        // appending at the tail needs no shift
                        state_in = (pos_c <= cnt_c) ? S_INS : S_INS_V;
                     end
                  end
                  KIND_DELETE: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else if (!pos_in_list) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        ptr_in   = ADDR_W'(pos_c);
                        end_in   = ADDR_W'(count_ff - CNT_W'(1));
                        // removing the tail needs no shift
                        state_in = (pos_c < cnt_c) ? S_DEL : S_RESP;
                     end
                  end
                  KIND_GET: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else if (!pos_in_list) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  KIND_LOCATE: begin
                     status_in = STATUS_NOT_FOUND;
                     ptr_in    = '0;
                     end_in    = ADDR_W'(count_ff - CNT_W'(1));
                     if (!is_empty) begin
                        state_in = S_LOC;
                     end
                  end
                  KIND_REVERSE: begin
                     ptr_in = '0;
                     end_in = ADDR_W'(count_ff - CNT_W'(1));
                     if (count_ff >= CNT_W'(2)) begin
                        state_in = S_REV_RD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_INS: begin
            tag_in  = ptr_ff;
            pend_in = 1'b1;
            ptr_in  = ptr_ff - ADDR_W'(1);
            if ((ptr_ff - ADDR_W'(1)) == end_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DEL: begin
            tag_in  = ptr_ff - ADDR_W'(1);
            pend_in = 1'b1;
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (ptr_ff == end_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            pend_in  = 1'b0;
            state_in = (op_ff == KIND_INSERT) ? S_INS_V : S_RESP;
         end
         S_INS_V: begin
            state_in = S_RESP;
         end
         S_GET: begin
            rdval_in = from_elem(rd_data_a);
            state_in = S_RESP;
         end
         S_LOC: begin
            tag_in  = ptr_ff;
            pend_in = 1'b1;
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (pend_ff && (rd_data_a == value_ff)) begin
               status_in = STATUS_OK;
               found_in  = POS_W'({1'b0, tag_ff} + (ADDR_W + 1)'(1));
               pend_in   = 1'b0;
               state_in  = S_RESP;
            end else if (pend_ff && (tag_ff == end_ff)) begin
               pend_in  = 1'b0;
               state_in = S_RESP;
            end
         end
         S_REV_RD: begin
            state_in = S_REV_W1;
         end
         S_REV_W1: begin
            hold_in  = rd_data_a;
            state_in = S_REV_W2;
         end
         S_REV_W2: begin
            ptr_in   = ptr_ff + ADDR_W'(1);
            end_in   = end_ff - ADDR_W'(1);
            state_in = rev_more ? S_REV_W1 : S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_in.status         = status_ff;
               rsp_in.read_value     = rdval_ff;
               rsp_in.found_position = found_ff;
               rsp_in.list_length    = POS_W'(count_ff);
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      tag_ff    <= tag_in;
      value_ff  <= value_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   // A response ready to go reaches the output and frees the sequencer
   a_resp_handoff : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("response not handed to output register");

   // A valid insert grows the list by exactly one
   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_INSERT && ins_ok)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance the length");

   // The store is never written while the sequencer is idle
   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("RAM write while idle");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench top: directed and random list commands checked against a shadow list.
`timescale 1ns / 1ps

module tb_top;
   import plte_pkg::*;

   // Kind codes that the engine ignores; they must still answer with an ok status.
   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   // The longest command walks CAPACITY entries.
   localparam int DRAIN_CYCLES   = CAPACITY + 40;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_BLOCKS  = 13;
   localparam int BLOCK_SIZE     = 100;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow copy of the list and the responses still owed by the engine.
   elem_type shadow_list [CAPACITY];
   int       shadow_len;
   rsp_type  expected_rsp_q [$];

   int error_count   = 0;
   int hold_request  = 0;
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;

   positional_list_table_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one command to the shadow list and return the response it must produce.
   // Status checks follow the engine's priority: full and empty before position.
   function automatic rsp_type apply_list_command(input req_type r);
      rsp_type  res;
      elem_type v;
      elem_type t;
      int       p;
      int       j;
      res        = '0;
      res.status = STATUS_OK;
      v          = elem_type'(r.value);
      p          = r.position;
      case (r.kind)
         KIND_INSERT: begin
            if (shadow_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (p < 1 || p > shadow_len + 1) begin
               res.status = STATUS_BAD_POS;
            end else begin
               for (j = shadow_len; j >= p; j--) shadow_list[j] = shadow_list[j-1];
               shadow_list[p-1] = v;
               shadow_len++;
            end
         end
         KIND_DELETE: begin
            if (shadow_len < 1) begin
               res.status = STATUS_EMPTY;
            end else if (p < 1 || p > shadow_len) begin
               res.status = STATUS_BAD_POS;
            end else begin
               for (j = p; j < shadow_len; j++) shadow_list[j-1] = shadow_list[j];
               shadow_len--;
            end
         end
         KIND_GET: begin
            if (shadow_len < 1) begin
               res.status = STATUS_EMPTY;
            end else if (p < 1 || p > shadow_len) begin
               res.status = STATUS_BAD_POS;
            end else begin
               res.read_value = 32'(shadow_list[p-1]);
            end
         end
         KIND_LOCATE: begin
            // First match wins; scan stops there.
            res.status = STATUS_NOT_FOUND;
            for (j = 0; j < shadow_len; j++) begin
               if (shadow_list[j] == v) begin
                  res.status         = STATUS_OK;
                  res.found_position = POS_W'(j + 1);
                  break;
               end
            end
         end
         KIND_REVERSE: begin
            for (j = 0; j < shadow_len / 2; j++) begin
               t                          = shadow_list[j];
               shadow_list[j]             = shadow_list[shadow_len-1-j];
               shadow_list[shadow_len-1-j] = t;
            end
         end
         default: ;
      endcase
      res.list_length = POS_W'(shadow_len);
      return res;
   endfunction

   // Offer one request after a random gap and hold it until the engine takes it.
   // Valid stays high across back-to-back requests; only the payload changes.
   task automatic send_request(input logic [2:0] kind, input int pos,
                               input logic signed [31:0] value);
      req_type r;
      int      gap;
      r.kind     = kind;
      r.position = POS_W'(pos);
      r.value    = value;
      gap        = sender_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(apply_list_command(r));
   endtask

   task automatic wait_for_drain();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Draw a mostly well-formed command against the current list; grow_pct steers
   // inserts versus deletes so the length sweeps between empty and full.
   function automatic req_type random_request(input int grow_pct);
      req_type r;
      int      roll;
      int      len;
      len  = shadow_len;
      roll = $urandom_range(0, 99);
      r.position = POS_W'($urandom);
      r.value    = $urandom;
      if (roll < 4) begin
         // Noise: any kind at all, including the unused codes.
         r.kind = 3'($urandom_range(0, 7));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 50)
            r.kind = ($urandom_range(0, 99) < grow_pct) ? KIND_INSERT : KIND_DELETE;
         else if (roll < 78)
            r.kind = KIND_GET;
         else if (roll < 94)
            r.kind = KIND_LOCATE;
         else
            r.kind = KIND_REVERSE;
         // Keep most positions legal; the rest fall anywhere in the 7-bit field.
         if ($urandom_range(0, 99) < 90) begin
            if (r.kind == KIND_INSERT)
               r.position = POS_W'($urandom_range(1, len + 1));
            else if (len > 0)
               r.position = POS_W'($urandom_range(1, len));
         end
         // Small values give duplicates, so locate sees first-match cases.
         roll = $urandom_range(0, 99);
         if (roll < 30)
            r.value = $signed($urandom_range(0, 7)) - 4;
         else if (roll < 34)
            r.value = 32'sh7FFF_FFFF;
         else if (roll < 38)
            r.value = 32'sh8000_0000;
         if (r.kind == KIND_LOCATE && len > 0 && $urandom_range(0, 99) < 70)
            r.value = 32'(shadow_list[$urandom_range(0, len - 1)]);
      end
      return r;
   endfunction

   task automatic send_random(input int count, input int grow_pct);
      req_type r;
      repeat (count) begin
         r = random_request(grow_pct);
         send_request(r.kind, r.position, r.value);
      end
   endtask

   // Empty-list behavior, rejected positions, list ends, extreme values and spare kinds.
   task automatic test_directed_corners();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_request(KIND_GET,     1, 0);
      send_request(KIND_DELETE,  1, 0);
      send_request(KIND_LOCATE,  0, 0);
      send_request(KIND_REVERSE, 0, 0);
      send_request(KIND_INSERT,  0, 5);
      send_request(KIND_INSERT,  2, 5);
      send_request(KIND_INSERT,  1, 32'sh7FFF_FFFF);
      send_request(KIND_REVERSE, 0, 0);
      send_request(KIND_INSERT,  2, 32'sh8000_0000);
      send_request(KIND_INSERT,  1, -1);
      send_request(KIND_INSERT,  2, 0);
      send_request(KIND_GET,     0, 0);
      send_request(KIND_GET,   127, 0);
      send_request(KIND_GET,     4, 0);
      send_request(KIND_LOCATE,  0, 32'sh8000_0000);
      send_request(KIND_LOCATE,  0, 12345);
      send_request(KIND_INSERT,  4, -1);
      send_request(KIND_LOCATE,  0, -1);
      send_request(KIND_REVERSE, 0, 0);
      send_request(KIND_DELETE,  6, 0);
      send_request(KIND_DELETE,  5, 0);
      send_request(KIND_DELETE,  1, 0);
      send_request(KIND_SPARE_5, 1, -1);
      send_request(KIND_SPARE_6, 127, 32'sh7FFF_FFFF);
      send_request(KIND_SPARE_7, 0, 0);
   endtask

   // Grow the list to capacity, then hit full, the top position and a full reverse.
   task automatic test_fill_to_capacity();
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      while (shadow_len < CAPACITY)
         send_request(KIND_INSERT, $urandom_range(1, shadow_len + 1), $urandom);
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_request(KIND_INSERT,  1, 7);
      send_request(KIND_INSERT,  0, 7);
      send_request(KIND_GET,     CAPACITY, 0);
      send_request(KIND_LOCATE,  0, shadow_list[CAPACITY-1]);
      send_request(KIND_REVERSE, 0, 0);
      send_request(KIND_GET,     1, 0);
      send_request(KIND_DELETE,  CAPACITY, 0);
      send_request(KIND_INSERT,  CAPACITY + 1, 9);
      send_request(KIND_INSERT,  CAPACITY, 32'sh8000_0000);
      send_request(KIND_LOCATE,  0, 32'sh8000_0000);
      send_request(KIND_INSERT,  CAPACITY, 9);
   endtask

   // Hold the response side off for a long stretch while requests keep coming,
   // so the output register fills and the engine stalls its input.
   task automatic test_output_backpressure();
      sender_idle   = 1'b0;
      receiver_idle = 1'b1;
      hold_request  = LONG_HOLD;
      send_random(40, 50);
   endtask

   // Stop sending until every owed response is back, a few times over.
   task automatic test_drain_pause();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      repeat (3) begin
         send_random(30, 50);
         // drop valid so the last request is not offered again
         req_valid <= 1'b0;
         wait_for_drain();
      end
   endtask

   // Bulk random traffic; blocks alternate the length trend and who idles.
   task automatic test_random_mix();
      int grow_plan [RANDOM_BLOCKS] = '{85, 50, 15, 90, 50, 10, 70, 30, 95, 5, 50, 60, 40};
      int b;
      for (b = 0; b < RANDOM_BLOCKS; b++) begin
         sender_idle   = (b % 4 == 0) || (b % 4 == 1);
         receiver_idle = (b % 4 == 0) || (b % 4 == 2);
         send_random(BLOCK_SIZE, grow_plan[b]);
      end
   endtask

   // Response side: draw a stall length per response, or take a long hold when asked.
   initial begin : response_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         if (hold_request > 0) begin
            wait_cycles  = hold_request;
            hold_request = 0;
         end else begin
            wait_cycles = receiver_idle ? $urandom_range(0, 15) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted response with the oldest owed one.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got %p",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            report_field("status",         want.status,         rsp_data.status);
            report_field("read_value",     want.read_value,     rsp_data.read_value);
            report_field("found_position", want.found_position, rsp_data.found_position);
            report_field("list_length",    want.list_length,    rsp_data.list_length);
         end
      end
   end

   // Drop the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : test_sequence
      shadow_len = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_fill_to_capacity();
      test_output_backpressure();
      test_drain_pause();
      test_random_mix();
      req_valid <= 1'b0;
      wait_for_drain();
      // Allow any stray response to show up before closing.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

### positional_list_table_engine.f
hw/rtl/plte_pkg.sv
hw/rtl/plte_ram.sv
hw/rtl/positional_list_table_engine.sv
dv/tb_top.sv
